/* hdl/qrm_pkg.sv */
// ---------------------------------------------------------------------------
// qrm_pkg
// Shared widths, types and helpers for the quaternion to rotation matrix block.
// ---------------------------------------------------------------------------
package qrm_pkg;

  localparam int IN_WIDTH      = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int OUT_W         = OUT_FRAC_BITS + 2;
  localparam int PROD_W        = 2 * IN_WIDTH;
  localparam int N_W           = PROD_W + 1;
  localparam int REM_W         = N_W + 1;
  localparam int Q_W           = OUT_FRAC_BITS + 2;
  localparam int STEPS         = OUT_FRAC_BITS + 2;
  localparam int NUM_ENT       = 9;

  localparam logic [OUT_W-1:0] ONE_Q = OUT_W'(1) << OUT_FRAC_BITS;

  typedef struct packed {
    logic                          minus;
    logic [N_W-1:0]                mag;
  } sdiff_t;

  typedef struct packed {
    logic                          zero;
    logic [N_W-1:0]                n;
    logic [NUM_ENT-1:0]            minus;
    logic [NUM_ENT-1:0][N_W-1:0]   diff;
  } job_t;

  typedef struct packed {
    logic                          zero;
    logic [NUM_ENT-1:0][OUT_W-1:0] ent;
  } res_t;

  // n - 2(sa + sb), as sign and magnitude
  function automatic sdiff_t diag_diff(logic [N_W-1:0] n, logic [PROD_W-1:0] sa,
                                       logic [PROD_W-1:0] sb);
    logic signed [N_W+2:0] d;
    sdiff_t r;
    d = $signed({3'b000, n}) - $signed({2'b00, {1'b0, sa} + {1'b0, sb}, 1'b0});
    r.minus = d[N_W+2];
    r.mag   = r.minus ? N_W'(-d) : N_W'(d);
    return r;
  endfunction

  // 2(t1 +- t2), as sign and magnitude
  function automatic sdiff_t offd_diff(logic signed [PROD_W-1:0] t1,
                                       logic signed [PROD_W-1:0] t2, logic sub);
    logic signed [PROD_W+1:0] s;
    sdiff_t r;
    s = sub ? (PROD_W'(0) + ({{2{t1[PROD_W-1]}}, t1} - {{2{t2[PROD_W-1]}}, t2}))
            : ({{2{t1[PROD_W-1]}}, t1} + {{2{t2[PROD_W-1]}}, t2});
    s = s <<< 1;
    r.minus = s[PROD_W+1];
    r.mag   = r.minus ? N_W'(-s) : N_W'(s);
    return r;
  endfunction

endpackage

/* hdl/qrm_front.sv */
// ---------------------------------------------------------------------------
// qrm_front
// Takes quaternions, forms the products, the norm and each entry's numerator.
// ---------------------------------------------------------------------------
module qrm_front import qrm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic signed [IN_WIDTH-1:0] comp_w,
  input  logic signed [IN_WIDTH-1:0] comp_x,
  input  logic signed [IN_WIDTH-1:0] comp_y,
  input  logic signed [IN_WIDTH-1:0] comp_z,
  output logic                       job_valid,
  input  logic                       job_full,
  output job_t                       job
);

  logic s1_valid;
  logic s2_valid;
  logic adv;
  logic signed [PROD_W-1:0] pww, pxx, pyy, pzz, pxy, pzw, pxz, pyw, pyz, pxw;
  logic [N_W-1:0] n_sum;
  sdiff_t e [NUM_ENT];

  assign adv       = !s2_valid || !job_full;
  assign full      = !adv;
  assign job_valid = s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= push;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pww <= comp_w * comp_w;
      pxx <= comp_x * comp_x;
      pyy <= comp_y * comp_y;
      pzz <= comp_z * comp_z;
      pxy <= comp_x * comp_y;
      pzw <= comp_z * comp_w;
      pxz <= comp_x * comp_z;
      pyw <= comp_y * comp_w;
      pyz <= comp_y * comp_z;
      pxw <= comp_x * comp_w;
    end
  end

  always_comb begin
    n_sum = N_W'(unsigned'(pww)) + N_W'(unsigned'(pxx))
          + N_W'(unsigned'(pyy)) + N_W'(unsigned'(pzz));
    e[0] = diag_diff(n_sum, pyy, pzz);
    e[1] = offd_diff(pxy, pzw, 1'b1);
    e[2] = offd_diff(pxz, pyw, 1'b0);
    e[3] = offd_diff(pxy, pzw, 1'b0);
    e[4] = diag_diff(n_sum, pxx, pzz);
    e[5] = offd_diff(pyz, pxw, 1'b1);
    e[6] = offd_diff(pxz, pyw, 1'b1);
    e[7] = offd_diff(pyz, pxw, 1'b0);
    e[8] = diag_diff(n_sum, pxx, pyy);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      job.n    <= n_sum;
      job.zero <= (n_sum == '0);
      for (int i = 0; i < NUM_ENT; i++) begin
        job.minus[i] <= e[i].minus;
        job.diff[i]  <= e[i].mag;
      end
    end
  end

endmodule

/* hdl/qrm_job_queue.sv */
// ---------------------------------------------------------------------------
// qrm_job_queue
// Two-entry queue between the front end and the divider pipeline.
// ---------------------------------------------------------------------------
module qrm_job_queue import qrm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  job_t wr_data,
  output logic full,
  input  logic rd,
  output job_t rd_data,
  output logic empty
);

  job_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) wr_ptr <= !wr_ptr;
      if (rd) rd_ptr <= !rd_ptr;
      count <= count + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slot[wr_ptr] <= wr_data;
  end

endmodule

/* hdl/qrm_back.sv */
// ---------------------------------------------------------------------------
// qrm_back
// Bit-per-stage restoring divider for the nine entries, rounding and a
// two-entry result queue.
// ---------------------------------------------------------------------------
module qrm_back import qrm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic job_empty,
  input  job_t job,
  output logic job_rd,
  output logic empty,
  input  logic pop,
  output res_t res
);

  logic                 valid [STEPS];
  logic [N_W-1:0]       n     [STEPS];
  logic                 zero  [STEPS];
  logic [NUM_ENT-1:0]   minus [STEPS];
  logic [N_W-1:0]       rem   [STEPS][NUM_ENT];
  logic [Q_W-1:0]       quo   [STEPS][NUM_ENT];
  logic                 adv;
  logic                 out_full;
  logic                 out_wr;
  res_t                 fin;
  res_t                 slot [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;

  assign adv    = !valid[STEPS-1] || !out_full;
  assign job_rd = adv && !job_empty;
  assign out_wr = valid[STEPS-1] && !out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < STEPS; s++) valid[s] <= 1'b0;
    end else if (adv) begin
      valid[0] <= !job_empty;
      for (int s = 1; s < STEPS; s++) valid[s] <= valid[s-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [REM_W-1:0] a;
    logic             ge;
    if (adv) begin
      n[0]     <= job.n;
      zero[0]  <= job.zero;
      minus[0] <= job.minus;
      for (int i = 0; i < NUM_ENT; i++) begin
        ge = (job.diff[i] >= job.n);
        rem[0][i] <= ge ? job.diff[i] - job.n : job.diff[i];
        quo[0][i] <= Q_W'(ge);
      end
      for (int s = 1; s < STEPS; s++) begin
        n[s]     <= n[s-1];
        zero[s]  <= zero[s-1];
        minus[s] <= minus[s-1];
        for (int i = 0; i < NUM_ENT; i++) begin
          a  = {rem[s-1][i], 1'b0};
          ge = (a >= {1'b0, n[s-1]});
          rem[s][i] <= ge ? N_W'(a - {1'b0, n[s-1]}) : N_W'(a);
          quo[s][i] <= {quo[s-1][i][Q_W-2:0], ge};
        end
      end
    end
  end

  // round half up, clamp to one, apply sign; zero norm gives identity
  always_comb begin
    logic [Q_W:0]     r;
    logic [OUT_W-1:0] mag;
    fin.zero = zero[STEPS-1];
    for (int i = 0; i < NUM_ENT; i++) begin
      r   = ({1'b0, quo[STEPS-1][i]} + (Q_W+1)'(1)) >> 1;
      mag = (r > (Q_W+1)'(ONE_Q)) ? ONE_Q : OUT_W'(r);
      if (zero[STEPS-1]) begin
        fin.ent[i] = (i % 4 == 0) ? ONE_Q : '0;
      end else begin
        fin.ent[i] = minus[STEPS-1][i] ? OUT_W'(-mag) : mag;
      end
    end
  end

  assign out_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign res      = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (out_wr) wr_ptr <= !wr_ptr;
      if (pop && !empty) rd_ptr <= !rd_ptr;
      count <= count + 2'(out_wr) - 2'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (out_wr) slot[wr_ptr] <= fin;
  end

endmodule

/* hdl/quaternion_to_rotation_matrix.sv */
// path: an accepted item passes the product and job registers, the job queue, the divider stages and the result queue
// throughput: one item per cycle while full stays low, set by the 16-stage divider pipeline
// that produces one quotient bit per stage for all nine entries at once
// reset: synchronous, active high; clears all valid bits and both queues
// ---------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Normalized quaternion to 3x3 rotation matrix in Q1.14, row by row.
// ---------------------------------------------------------------------------
module quaternion_to_rotation_matrix import qrm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic signed [IN_WIDTH-1:0] comp_w,
  input  logic signed [IN_WIDTH-1:0] comp_x,
  input  logic signed [IN_WIDTH-1:0] comp_y,
  input  logic signed [IN_WIDTH-1:0] comp_z,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [OUT_W-1:0]    row0_col0,
  output logic signed [OUT_W-1:0]    row0_col1,
  output logic signed [OUT_W-1:0]    row0_col2,
  output logic signed [OUT_W-1:0]    row1_col0,
  output logic signed [OUT_W-1:0]    row1_col1,
  output logic signed [OUT_W-1:0]    row1_col2,
  output logic signed [OUT_W-1:0]    row2_col0,
  output logic signed [OUT_W-1:0]    row2_col1,
  output logic signed [OUT_W-1:0]    row2_col2,
  output logic                       zero_norm
);

  logic job_valid;
  logic job_full;
  logic job_empty;
  logic job_rd;
  logic job_wr;
  job_t front_job;
  job_t back_job;
  res_t res;

  assign job_wr = job_valid && !job_full;

  qrm_front u_front (
    .clk, .rst, .push, .full, .comp_w, .comp_x, .comp_y, .comp_z,
    .job_valid, .job_full, .job(front_job)
  );

  qrm_job_queue u_queue (
    .clk, .rst, .wr(job_wr), .wr_data(front_job), .full(job_full),
    .rd(job_rd), .rd_data(back_job), .empty(job_empty)
  );

  qrm_back u_back (
    .clk, .rst, .job_empty, .job(back_job), .job_rd, .empty, .pop, .res
  );

  assign row0_col0 = res.ent[0];
  assign row0_col1 = res.ent[1];
  assign row0_col2 = res.ent[2];
  assign row1_col0 = res.ent[3];
  assign row1_col1 = res.ent[4];
  assign row1_col2 = res.ent[5];
  assign row2_col0 = res.ent[6];
  assign row2_col1 = res.ent[7];
  assign row2_col2 = res.ent[8];
  assign zero_norm = res.zero;

endmodule
